FILE: src/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants for the sliding window minimum/maximum block.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;

  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } swmm_state_e;

  // Strobes from the sequencer to the sample store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } swmm_mem_ctl_t;

endpackage

FILE: src/swmm_store.sv
// ----------------------------------------------------------------------------
// swmm_store
// Ring store of samples: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module swmm_store
  import swmm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AddrW = $clog2(CAPACITY)
) (
  input  logic                     clk_i,
  input  swmm_mem_ctl_t            ctl_i,
  input  logic [AddrW-1:0]         wr_addr_i,
  input  logic signed [DATA_W-1:0] wr_data_i,
  input  logic [AddrW-1:0]         rd_addr_i,
  output logic signed [DATA_W-1:0] rd_data_o
);

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/swmm_minmax_unit.sv
// ----------------------------------------------------------------------------
// swmm_minmax_unit
// Shared compare unit: folds one candidate into a maximum and a minimum.
// ----------------------------------------------------------------------------
module swmm_minmax_unit
  import swmm_pkg::*;
(
  input  logic signed [DATA_W-1:0] cand_i,
  input  logic signed [DATA_W-1:0] hi_i,
  input  logic signed [DATA_W-1:0] lo_i,
  output logic signed [DATA_W-1:0] hi_o,
  output logic signed [DATA_W-1:0] lo_o
);

  assign hi_o = (cand_i > hi_i) ? cand_i : hi_i;
  assign lo_o = (cand_i < lo_i) ? cand_i : lo_i;

endmodule

FILE: src/sliding_window_min_max_top.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_top
// Window maximum and minimum over the last CAPACITY signed samples.
// ----------------------------------------------------------------------------
// Each accepted item writes its sample into a ring store, overwriting the
// oldest entry, and yields one result carrying the window maximum and
// minimum. Entries not yet written since reset count as zero; a fill count
// stands in for clearing the store, so no clearing pass runs after reset.
// An item normally passes from acceptance to result by way of the accept
// step, the read and write of the evicted entry, and the output register load.
// When the evicted entry was the current extreme and the new sample does not
// take its place, the whole store is rescanned through the single store read
// port and one shared compare unit, one entry per cycle, followed by a drain
// step, before the output register is loaded. A new item is not accepted
// until the current one has reached the output register; a result may wait
// there under stall while the next item is already being worked on.
// ----------------------------------------------------------------------------
module sliding_window_min_max_top
  import swmm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] window_max_o,
  output logic signed [DATA_W-1:0] window_min_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(CAPACITY - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(CAPACITY);

  swmm_state_e state_q, state_d;

  logic [AddrW-1:0]         wpos_q, wpos_d;
  logic [CntW-1:0]          fill_q, fill_d;
  logic [AddrW-1:0]         scan_q, scan_d;
  logic                     pend_q, pend_d;
  logic                     rd_zero_q, rd_zero_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] max_q, max_d;
  logic signed [DATA_W-1:0] min_q, min_d;
  logic signed [DATA_W-1:0] sample_q;
  logic signed [DATA_W-1:0] win_max_q;
  logic signed [DATA_W-1:0] win_min_q;

  swmm_mem_ctl_t            mem_ctl;
  logic [AddrW-1:0]         rd_addr;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] stored;
  logic signed [DATA_W-1:0] cand;
  logic signed [DATA_W-1:0] unit_hi;
  logic signed [DATA_W-1:0] unit_lo;
  logic                     in_acc;
  logic                     out_free;
  logic                     rescan;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // An entry at or beyond the fill count has not been written since reset.
  assign stored = rd_zero_q ? '0 : rd_data;

  assign rescan = ((stored == max_q) && (stored > sample_q)) ||
                  ((stored == min_q) && (stored < sample_q));

  // The compare unit sees the new sample while the evicted entry is checked,
  // and the stored entries during a rescan.
  assign cand = (state_q == ST_EVICT) ? sample_q : stored;

  swmm_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wpos_q),
    .wr_data_i (sample_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  swmm_minmax_unit u_unit (
    .cand_i (cand),
    .hi_i   (max_q),
    .lo_i   (min_q),
    .hi_o   (unit_hi),
    .lo_o   (unit_lo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        state_d = rescan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (scan_q == LastAddr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_ctl     = '0;
    rd_addr     = wpos_q;
    wpos_d      = wpos_q;
    fill_d      = fill_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    rd_zero_d   = rd_zero_q;
    max_d       = max_q;
    min_d       = min_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mem_ctl.rd_en = 1'b1;
          rd_zero_d     = !(CntW'(wpos_q) < fill_q);
        end
      end
      ST_EVICT: begin
        mem_ctl.wr_en = 1'b1;
        wpos_d        = (wpos_q == LastAddr) ? '0 : wpos_q + 1'b1;
        fill_d        = (fill_q == FullCnt) ? fill_q : fill_q + 1'b1;
        scan_d        = '0;
        if (rescan) begin
          max_d = DATA_MIN;
          min_d = DATA_MAX;
        end else begin
          max_d = unit_hi;
          min_d = unit_lo;
        end
      end
      ST_SCAN: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = scan_q;
        // The fill count already includes the entry written for this item.
        rd_zero_d     = !(CntW'(scan_q) < fill_q);
        pend_d        = 1'b1;
        scan_d        = scan_q + 1'b1;
        if (pend_q) begin
          max_d = unit_hi;
          min_d = unit_lo;
        end
      end
      ST_DRAIN: begin
        max_d = unit_hi;
        min_d = unit_lo;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wpos_q      <= '0;
      fill_q      <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      rd_zero_q   <= 1'b1;
      out_valid_q <= 1'b0;
      max_q       <= '0;
      min_q       <= '0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      rd_zero_q   <= rd_zero_d;
      out_valid_q <= out_valid_d;
      max_q       <= max_d;
      min_q       <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
    end
    if ((state_q == ST_DONE) && out_free) begin
      win_max_q <= max_q;
      win_min_q <= min_q;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign window_max_o = win_max_q;
  assign window_min_o = win_min_q;

endmodule
